// ===== hw/rtl/two_button_press_classifier_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the two-button press classifier
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef TWO_BUTTON_PRESS_CLASSIFIER_TOP_ASSERT_SVH
`define TWO_BUTTON_PRESS_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication
`define TBPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TBPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tbpc_pkg.sv =====
// ---------------------------------------------------------------------------
// tbpc_pkg
// Types, register indexes and reset values of the two-button classifier.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tbpc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned LimW  = 16;
  localparam int unsigned IdxW  = 3;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_INVALID   = 3'd1,
    EV_SHORT     = 3'd2,
    EV_LONG      = 3'd3,
    EV_BOTH_LONG = 3'd4,
    EV_STUCK     = 3'd5
  } ev_e;

  typedef enum logic [IdxW-1:0] {
    REG_BOUNCE_LIMIT = 3'd0,
    REG_SHORT_LOW    = 3'd1,
    REG_SHORT_HIGH   = 3'd2,
    REG_LONG_LOW     = 3'd3,
    REG_LONG_HIGH    = 3'd4,
    REG_FAULT_LIMIT  = 3'd5
  } reg_e;

  localparam logic [LimW-1:0] BounceLimitRst = 16'd50;
  localparam logic [LimW-1:0] ShortLowRst    = 16'd50;
  localparam logic [LimW-1:0] ShortHighRst   = 16'd1000;
  localparam logic [LimW-1:0] LongLowRst     = 16'd1500;
  localparam logic [LimW-1:0] LongHighRst    = 16'd2500;
  localparam logic [LimW-1:0] FaultLimitRst  = 16'd5000;

  typedef struct packed {
    logic [LimW-1:0] bounce_limit;
    logic [LimW-1:0] short_low;
    logic [LimW-1:0] short_high;
    logic [LimW-1:0] long_low;
    logic [LimW-1:0] long_high;
    logic [LimW-1:0] fault_limit;
  } cfg_t;

  // per-channel update control
  typedef struct packed {
    logic step;     // transaction leaves the input register this cycle
    logic restart;  // that transaction is a restart command
  } chan_ctrl_t;

endpackage

// ===== hw/rtl/tbpc_chan.sv =====
// ---------------------------------------------------------------------------
// tbpc_chan
// One button channel: timestamp, held and combo flags, event decode.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbpc_chan import tbpc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  chan_ctrl_t       ctrl_i,
  input  cfg_t             cfg_i,
  input  logic [TimeW-1:0] now_i,
  input  logic             own_i,
  input  logic             other_i,
  output ev_e              ev_o
);

  logic [TimeW-1:0] stamp_q, stamp_d;
  logic             held_q, held_d;
  logic             combo_q, combo_d;

  logic [TimeW-1:0] elapsed;
  logic             in_long;
  logic             own_alone;
  logic             held_arm;
  ev_e              ev;

  // a released channel restamps to now, so elapsed is zero
  assign elapsed   = held_q ? (now_i - stamp_q) : '0;
  assign in_long   = (elapsed > TimeW'(cfg_i.long_low)) && (elapsed < TimeW'(cfg_i.long_high));
  assign own_alone = own_i && !other_i;
  assign held_arm  = held_q || (own_alone && (elapsed < TimeW'(cfg_i.short_high)));

  always_comb begin
    held_d  = held_arm;
    combo_d = combo_q;
    ev      = EV_NONE;
    if (own_alone && !combo_q && in_long) begin
      held_d  = 1'b1;
      combo_d = 1'b1;
      ev      = EV_LONG;
    end else if (own_i && other_i && !combo_q && in_long) begin
      held_d  = 1'b1;
      combo_d = 1'b1;
      ev      = EV_BOTH_LONG;
    end else if (held_arm && !own_i) begin
      held_d  = 1'b0;
      combo_d = 1'b0;
      if (elapsed <= TimeW'(cfg_i.bounce_limit)) begin
        ev = EV_INVALID;
      end else if ((elapsed > TimeW'(cfg_i.short_low)) &&
                   (elapsed < TimeW'(cfg_i.short_high))) begin
        ev = EV_SHORT;
      end else if (elapsed > TimeW'(cfg_i.fault_limit)) begin
        ev = EV_STUCK;
      end
    end else if (own_i && (elapsed >= TimeW'(cfg_i.long_high))) begin
      held_d = 1'b1;
      ev     = EV_STUCK;
    end
  end

  // restart keeps the flags and reports nothing
  always_comb begin
    if (ctrl_i.restart) begin
      stamp_d = now_i;
    end else begin
      stamp_d = held_q ? stamp_q : now_i;
    end
  end

  assign ev_o = ctrl_i.restart ? EV_NONE : ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_q <= '0;
      held_q  <= 1'b0;
      combo_q <= 1'b0;
    end else if (ctrl_i.step) begin
      stamp_q <= stamp_d;
      if (!ctrl_i.restart) begin
        held_q  <= held_d;
        combo_q <= combo_d;
      end
    end
  end

endmodule

// ===== hw/rtl/two_button_press_classifier_top.sv =====
// ---------------------------------------------------------------------------
// two_button_press_classifier_top
// Classifies presses of two buttons into invalid, short, long, both-long and
// stuck-fault events from a stream of timed polls.
// ---------------------------------------------------------------------------
// Each accepted poll gives exactly one result holding an event for each
// button. Throughput is one transaction per clock while the output is not
// stalled: a poll is captured in an input register and decoded in a single
// stage into the result register, where both channel states update in the
// same cycle. A stalled output holds the poll in the input register. The
// input register doubles as a skid stage, so one poll is still accepted
// while a result waits. Threshold registers must be written by the user
// through the cfg port while no transaction is in flight (unchecked).
`timescale 1ns / 1ps

module two_button_press_classifier_top import tbpc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             cfg_we_i,
  input  logic [IdxW-1:0]  cfg_idx_i,
  input  logic [LimW-1:0]  cfg_wdata_i,
  // poll input
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             command_i,
  input  logic [TimeW-1:0] now_i,
  input  logic             mode_pressed_i,
  input  logic             set_pressed_i,
  // event output
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       mode_event_o,
  output logic [2:0]       set_event_o
);

  cfg_t cfg_q, cfg_d;

  logic             in_valid_q, in_valid_d;
  logic             cmd_q;
  logic [TimeW-1:0] now_q;
  logic             mode_q, set_q;
  logic             out_valid_q, out_valid_d;
  ev_e              mode_ev_q, set_ev_q;
  ev_e              mode_ev, set_ev;

  logic       in_accept;
  logic       advance;
  chan_ctrl_t ctrl;

  // ---- configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_BOUNCE_LIMIT: cfg_d.bounce_limit = cfg_wdata_i;
        REG_SHORT_LOW:    cfg_d.short_low    = cfg_wdata_i;
        REG_SHORT_HIGH:   cfg_d.short_high   = cfg_wdata_i;
        REG_LONG_LOW:     cfg_d.long_low     = cfg_wdata_i;
        REG_LONG_HIGH:    cfg_d.long_high    = cfg_wdata_i;
        REG_FAULT_LIMIT:  cfg_d.fault_limit  = cfg_wdata_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bounce_limit <= BounceLimitRst;
      cfg_q.short_low    <= ShortLowRst;
      cfg_q.short_high   <= ShortHighRst;
      cfg_q.long_low     <= LongLowRst;
      cfg_q.long_high    <= LongHighRst;
      cfg_q.fault_limit  <= FaultLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---- handshake
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ---- input register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q  <= command_i;
      now_q  <= now_i;
      mode_q <= mode_pressed_i;
      set_q  <= set_pressed_i;
    end
  end

  // ---- channels
  assign ctrl.step    = advance;
  assign ctrl.restart = cmd_q;

  tbpc_chan u_mode_chan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .cfg_i   (cfg_q),
    .now_i   (now_q),
    .own_i   (mode_q),
    .other_i (set_q),
    .ev_o    (mode_ev)
  );

  tbpc_chan u_set_chan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .cfg_i   (cfg_q),
    .now_i   (now_q),
    .own_i   (set_q),
    .other_i (mode_q),
    .ev_o    (set_ev)
  );

  // ---- result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      mode_ev_q <= mode_ev;
      set_ev_q  <= set_ev;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign mode_event_o = mode_ev_q;
  assign set_event_o  = set_ev_q;

endmodule

// ===== hw/rtl/tbpc_check.sv =====
// ---------------------------------------------------------------------------
// tbpc_check
// Port-level checks of the two-button classifier, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "two_button_press_classifier_top_assert.svh"

module tbpc_check import tbpc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] mode_event_o,
  input logic [2:0] set_event_o
);

  // stalled result holds
  `TBPC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(mode_event_o) && $stable(set_event_o), "stalled result changed")

  // a lone long press needs the other button released
  `TBPC_ASSERT_NOW(a_no_dual_long, out_valid_o, !((mode_event_o == EV_LONG) && (set_event_o == EV_LONG)), "both buttons report a lone long press")

  // both-long means both held: the other side cannot report a release
  `TBPC_ASSERT_NOW(a_mode_both, out_valid_o && (mode_event_o == EV_BOTH_LONG), (set_event_o == EV_NONE) || (set_event_o == EV_BOTH_LONG) || (set_event_o == EV_STUCK), "set event conflicts with mode both-long")

  `TBPC_ASSERT_NOW(a_set_both, out_valid_o && (set_event_o == EV_BOTH_LONG), (mode_event_o == EV_NONE) || (mode_event_o == EV_BOTH_LONG) || (mode_event_o == EV_STUCK), "mode event conflicts with set both-long")

endmodule

bind two_button_press_classifier_top tbpc_check u_tbpc_check (.*);

// ===== tb/two_button_press_classifier_top_tb.sv =====
// ---------------------------------------------------------------------------
// Two-button press classifier testbench
// Streams timed polls of both buttons through the classifier and checks
// every event pair against an in-bench predictor of the two channels. The
// run covers several threshold settings and random idling on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_button_press_classifier_top_tb;
  import tbpc_pkg::*;

  localparam logic [IdxW-1:0] RegSpareA = 3'd6;
  localparam logic [IdxW-1:0] RegSpareB = 3'd7;

  typedef struct packed {
    logic             cmd;
    logic [TimeW-1:0] now;
    logic             mode_p;
    logic             set_p;
  } poll_t;

  typedef struct packed {
    ev_e mode_ev;
    ev_e set_ev;
  } ev_pair_t;

  typedef struct packed {
    logic [TimeW-1:0] stamp;
    logic             held;
    logic             combo;
  } chan_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [IdxW-1:0]  cfg_idx_i = '0;
  logic [LimW-1:0]  cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic             command_i = 1'b0;
  logic [TimeW-1:0] now_i = '0;
  logic             mode_pressed_i = 1'b0;
  logic             set_pressed_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [2:0]       mode_event_o;
  logic [2:0]       set_event_o;

  two_button_press_classifier_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .now_i          (now_i),
    .mode_pressed_i (mode_pressed_i),
    .set_pressed_i  (set_pressed_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mode_event_o   (mode_event_o),
    .set_event_o    (set_event_o)
  );

  always #6 clk_i = ~clk_i;

  // predictor state
  cfg_t  lim;
  chan_t mode_ch;
  chan_t set_ch;

  poll_t    poll_q[$];
  ev_pair_t event_q[$];

  int unsigned err_cnt = 0;
  int unsigned n_in = 0;
  bit          quiet = 1'b0;
  logic [TimeW-1:0] tick;

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic ev_e step_channel(inout chan_t ch, input logic [TimeW-1:0] now,
                                       input logic own, input logic other);
    logic [TimeW-1:0] el;
    logic             in_long;
    ev_e              ev;
    if (!ch.held) ch.stamp = now;
    el = now - ch.stamp;
    in_long = (el > lim.long_low) && (el < lim.long_high);
    if (own && !other && el < lim.short_high) ch.held = 1'b1;
    if (own && !ch.combo && in_long) begin
      ch.held  = 1'b1;
      ch.combo = 1'b1;
      return other ? EV_BOTH_LONG : EV_LONG;
    end
    if (ch.held && !own) begin
      ev = EV_NONE;
      if (el <= lim.bounce_limit) ev = EV_INVALID;
      else if (el > lim.short_low && el < lim.short_high) ev = EV_SHORT;
      else if (el > lim.fault_limit) ev = EV_STUCK;
      ch.held  = 1'b0;
      ch.combo = 1'b0;
      return ev;
    end
    if (own && el >= lim.long_high) begin
      ch.held = 1'b1;
      return EV_STUCK;
    end
    return EV_NONE;
  endfunction

  function automatic ev_pair_t classify_poll(input poll_t p);
    ev_pair_t r;
    if (p.cmd) begin
      mode_ch.stamp = p.now;
      set_ch.stamp  = p.now;
      r.mode_ev = EV_NONE;
      r.set_ev  = EV_NONE;
    end else begin
      r.mode_ev = step_channel(mode_ch, p.now, p.mode_p, p.set_p);
      r.set_ev  = step_channel(set_ch, p.now, p.set_p, p.mode_p);
    end
    return r;
  endfunction

  // driver: presents the head of poll_q, with random gaps between transactions
  int unsigned snd_gap = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        event_q.push_back(classify_poll(poll_q.pop_front()));
        n_in <= n_in + 1;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (snd_gap > 0) begin
          snd_gap--;
          in_valid_i <= 1'b0;
        end else if (poll_q.size() > 0 && !quiet && $urandom_range(0, 15) == 0) begin
          snd_gap = $urandom_range(1, 11) - 1;
          in_valid_i <= 1'b0;
        end else if (poll_q.size() > 0) begin
          in_valid_i     <= 1'b1;
          command_i      <= poll_q[0].cmd;
          now_i          <= poll_q[0].now;
          mode_pressed_i <= poll_q[0].mode_p;
          set_pressed_i  <= poll_q[0].set_p;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall: random bursts plus one long hold-off to back up the input
  int unsigned rcv_gap = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!hold_done && n_in >= 400) begin
      hold_done = 1'b1;
      hold_left = 79;
      out_stall_i <= 1'b1;
    end else if (rcv_gap > 0) begin
      rcv_gap--;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 12) == 0) begin
      rcv_gap = $urandom_range(1, 11) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    ev_pair_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (event_q.size() == 0) begin
        report_mismatch($sformatf("result %0d/%0d with nothing pending",
                                  mode_event_o, set_event_o));
      end else begin
        want = event_q.pop_front();
        if (mode_event_o !== want.mode_ev)
          report_mismatch($sformatf("mode_event %0d, want %0d", mode_event_o, want.mode_ev));
        if (set_event_o !== want.set_ev)
          report_mismatch($sformatf("set_event %0d, want %0d", set_event_o, want.set_ev));
      end
    end
  end

  task automatic add_poll(input logic cmd, input logic [TimeW-1:0] t,
                          input logic mp, input logic sp);
    poll_t p;
    p.cmd    = cmd;
    p.now    = t;
    p.mode_p = mp;
    p.set_p  = sp;
    poll_q.push_back(p);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [LimW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_BOUNCE_LIMIT: lim.bounce_limit = val;
      REG_SHORT_LOW:    lim.short_low    = val;
      REG_SHORT_HIGH:   lim.short_high   = val;
      REG_LONG_LOW:     lim.long_low     = val;
      REG_LONG_HIGH:    lim.long_high    = val;
      REG_FAULT_LIMIT:  lim.fault_limit  = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(input cfg_t c);
    write_reg(REG_BOUNCE_LIMIT, c.bounce_limit);
    write_reg(REG_SHORT_LOW, c.short_low);
    write_reg(REG_SHORT_HIGH, c.short_high);
    write_reg(REG_LONG_LOW, c.long_low);
    write_reg(REG_LONG_HIGH, c.long_high);
    write_reg(REG_FAULT_LIMIT, c.fault_limit);
    // unmapped indexes must leave the thresholds alone
    write_reg(RegSpareA, LimW'($urandom()));
    write_reg(RegSpareB, LimW'($urandom()));
  endtask

  // drain everything in flight, then let the pipeline settle
  task automatic drain;
    while (poll_q.size() != 0 || event_q.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  // hold times clustered around the current thresholds, or drawn at random
  function automatic int unsigned pick_hold();
    int     base;
    int     v;
    case ($urandom_range(0, 7))
      0: base = int'(lim.bounce_limit);
      1: base = int'(lim.short_low);
      2: base = int'(lim.short_high);
      3: base = int'(lim.long_low);
      4: base = int'(lim.long_high);
      5: base = int'(lim.fault_limit);
      6: return $urandom_range(1, 60);
      default: return $urandom_range(1, 70000);
    endcase
    v = base + $urandom_range(0, 4) - 2;
    return (v < 1) ? 1 : v;
  endfunction

  task automatic add_traffic(input int unsigned n);
    int unsigned start_cnt;
    int unsigned r;
    int unsigned hold;
    int unsigned k;
    int unsigned off;
    logic [TimeW-1:0] t0;
    logic mp;
    logic sp;
    start_cnt = poll_q.size();
    while (poll_q.size() - start_cnt < n) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        tick = tick + $urandom_range(0, 300);
        add_poll(1'b1, tick, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (r < 10) begin
        tick = $urandom();
        add_poll(1'b0, tick, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin mp = 1'b1; sp = 1'b0; end
          4, 5, 6, 7: begin mp = 1'b0; sp = 1'b1; end
          default:    begin mp = 1'b1; sp = 1'b1; end
        endcase
        hold = pick_hold();
        t0 = tick;
        add_poll(1'b0, t0, mp, sp);
        k = $urandom_range(0, 3);
        for (int i = 0; i < k; i++) begin
          off = pick_hold();
          if (off < hold) begin
            if ($urandom_range(0, 4) == 0)
              add_poll(1'b0, t0 + off, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
            else
              add_poll(1'b0, t0 + off, mp, sp);
          end
        end
        if (mp && sp && $urandom_range(0, 3) == 0)
          add_poll(1'b0, t0 + hold, 1'($urandom_range(0, 1)), 1'b0);
        else
          add_poll(1'b0, t0 + hold, 1'b0, 1'b0);
        tick = t0 + hold + $urandom_range(1, 200);
      end
    end
  endtask

  task automatic add_directed;
    add_poll(1'b0, 32'd0, 1'b0, 1'b0);
    add_poll(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1);
    // bounce, then the smallest short press
    add_poll(1'b0, 32'd100, 1'b1, 1'b0);
    add_poll(1'b0, 32'd130, 1'b0, 1'b0);
    add_poll(1'b0, 32'd1000, 1'b1, 1'b0);
    add_poll(1'b0, 32'd1051, 1'b0, 1'b0);
    // long on set, released inside the dead band
    add_poll(1'b0, 32'd2000, 1'b0, 1'b1);
    add_poll(1'b0, 32'd3501, 1'b0, 1'b1);
    add_poll(1'b0, 32'd3700, 1'b0, 1'b0);
    // mode armed alone, then both held into the long window
    add_poll(1'b0, 32'd5000, 1'b1, 1'b0);
    add_poll(1'b0, 32'd5010, 1'b1, 1'b1);
    add_poll(1'b0, 32'd6600, 1'b1, 1'b1);
    add_poll(1'b0, 32'd6700, 1'b0, 1'b0);
    // held exactly to long_high, then released past the fault limit
    add_poll(1'b0, 32'd10000, 1'b1, 1'b0);
    add_poll(1'b0, 32'd12500, 1'b1, 1'b0);
    add_poll(1'b0, 32'd16000, 1'b0, 1'b0);
    // restart while held keeps the flag but moves the stamp
    add_poll(1'b0, 32'd20000, 1'b0, 1'b1);
    add_poll(1'b1, 32'd20500, 1'b0, 1'b1);
    add_poll(1'b0, 32'd20600, 1'b0, 1'b0);
    // time wrapping forward, and time running backwards
    add_poll(1'b0, 32'hFFFF_FF00, 1'b1, 1'b0);
    add_poll(1'b0, 32'h0000_0100, 1'b0, 1'b0);
    add_poll(1'b0, 32'd50000, 1'b0, 1'b1);
    add_poll(1'b0, 32'd40000, 1'b0, 1'b0);
    // held straight to long_high: stuck, with no long reported first
    add_poll(1'b0, 32'd61600, 1'b1, 1'b0);
    add_poll(1'b0, 32'd64100, 1'b1, 1'b0);
  endtask

  initial begin
    cfg_t c;
    int unsigned lo;
    lim = '{bounce_limit: BounceLimitRst, short_low: ShortLowRst,
            short_high: ShortHighRst, long_low: LongLowRst,
            long_high: LongHighRst, fault_limit: FaultLimitRst};
    mode_ch = '0;
    set_ch  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset thresholds
    add_directed();
    tick = $urandom();
    add_traffic(250);
    drain();

    // ordered, realistic thresholds
    c.bounce_limit = LimW'($urandom_range(0, 200));
    c.short_low    = LimW'($urandom_range(0, 200));
    c.short_high   = LimW'($urandom_range(200, 2000));
    c.long_low     = LimW'($urandom_range(c.short_high, 4000));
    c.long_high    = LimW'($urandom_range(c.long_low + 1, 8000));
    c.fault_limit  = LimW'($urandom_range(c.long_high, 20000));
    write_all(c);
    @(negedge clk_i);
    add_traffic(200);
    drain();

    write_all('0);
    @(negedge clk_i);
    add_traffic(100);
    drain();

    write_all('1);
    @(negedge clk_i);
    add_traffic(100);
    drain();

    // tiny and unordered thresholds
    c.bounce_limit = LimW'($urandom_range(0, 20));
    c.short_low    = LimW'($urandom_range(0, 20));
    c.short_high   = LimW'($urandom_range(0, 20));
    c.long_low     = LimW'($urandom_range(0, 20));
    c.long_high    = LimW'($urandom_range(0, 20));
    c.fault_limit  = LimW'($urandom_range(0, 20));
    write_all(c);
    @(negedge clk_i);
    add_traffic(150);
    drain();

    // last part runs at full rate on both sides
    lo = $urandom_range(1000, 3000);
    c.bounce_limit = LimW'($urandom_range(10, 100));
    c.short_low    = c.bounce_limit;
    c.short_high   = LimW'($urandom_range(300, 1000));
    c.long_low     = LimW'(lo);
    c.long_high    = LimW'(lo + $urandom_range(1, 2000));
    c.fault_limit  = LimW'(c.long_high + $urandom_range(0, 5000));
    write_all(c);
    @(negedge clk_i);
    quiet = 1'b1;
    add_traffic(150);
    drain();

    if (event_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", event_q.size()));
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
